// ===== rtl/pprq_pkg.sv =====
// ----------------------------------------------------------------------------
// pprq_pkg: shared types and constants for the preemptive priority run queue
// Holds the default queue depth, the result status codes, the transaction kinds
// and the layout of one queue entry.
// ----------------------------------------------------------------------------
package pprq_pkg;

	localparam int unsigned QueueDepthDefault = 10;

	typedef enum logic [2:0] {
		ST_QUEUED      = 3'd0,
		ST_DROP_FULL   = 3'd1,
		ST_DROP_ZERO   = 3'd2,
		ST_FINISHED    = 3'd3,
		ST_FINISH_EMPTY = 3'd4
	} status_t;

	typedef enum logic {
		KIND_ARRIVAL = 1'b0,
		KIND_FINISH  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] tag;
		logic [7:0] prec;
	} entry_t;

endpackage

// ===== rtl/preemptive_priority_run_queue_unit.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_run_queue_unit: sorted run queue with preemption
// Keeps up to QUEUE_DEPTH jobs ordered by precedence; the front job runs.
// ----------------------------------------------------------------------------
// One transaction in, one result transaction out. Arrivals that are dropped,
// that land on an empty queue or that preempt the running job go straight to
// the result state, as does a finish event with at most one job held; an
// arrival that sorts in behind the running job walks the queue from its tail
// with a single precedence comparator, one entry per cycle, moving each entry
// it passes up one place and then writing the job into the gap; a finish
// event with two or more jobs held shifts the remaining count-1 entries down
// one place, one per cycle, through the single-port-write, single-port-read
// queue memory. The result state presents the result, and the block takes no
// new transaction until that result has been taken. A preempting arrival
// simply overwrites the front entry: the discarded job and its replacement
// occupy the same slot, so the count does not change. The queue memory needs
// no clearing after reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module preemptive_priority_run_queue_unit
	import pprq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] job_tag,
	input  logic [7:0] job_precedence,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic       preempted,
	output logic       running_valid,
	output logic [7:0] running_tag,
	output logic [7:0] running_precedence,
	output logic [3:0] queue_count
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_INS  = 4'b0010,
		S_FIN  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	// Queue storage: one write and one registered read per cycle
	entry_t mem [QUEUE_DEPTH];
	entry_t rd_q;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] idx_q, idx_d;
	entry_t        front_q, front_d;
	entry_t        new_q, new_d;
	status_t       status_q, status_d;
	logic          preempted_q, preempted_d;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic [AW-1:0] rd_addr;

	logic          q_empty;
	logic          q_full;
	logic [AW-1:0] last_idx;
	entry_t        arrival;

	// Shared precedence comparator: the front against the arrival when idle,
	// the entry just read against the held job while walking
	logic [7:0]    cmp_held;
	logic [7:0]    cmp_new;
	logic          cmp_lower;

	assign q_empty  = (count_q == '0);
	assign q_full   = (count_q == CW'(QUEUE_DEPTH));
	assign last_idx = AW'(count_q - 1'b1);
	assign arrival  = '{tag: job_tag, prec: job_precedence};

	assign cmp_held  = (state_q == S_INS) ? rd_q.prec  : front_q.prec;
	assign cmp_new   = (state_q == S_INS) ? new_q.prec : job_precedence;
	assign cmp_lower = (cmp_held < cmp_new);

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		front_d     = front_q;
		new_d       = new_q;
		status_d    = status_q;
		preempted_d = preempted_q;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = new_q;
		rd_addr     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					new_d       = arrival;
					preempted_d = 1'b0;
					state_d     = S_OUT;
					if (kind_t'(kind) == KIND_FINISH) begin
						// Remove the running job; shift the rest down if any remain
						if (q_empty) begin
							status_d = ST_FINISH_EMPTY;
						end else if (count_q == CW'(1)) begin
							status_d = ST_FINISHED;
							count_d  = '0;
						end else begin
							status_d = ST_FINISHED;
							rd_addr  = AW'(1);
							idx_d    = AW'(1);
							state_d  = S_FIN;
						end
					end else if (q_full) begin
						status_d = ST_DROP_FULL;
					end else if (job_precedence == '0 && !q_empty) begin
						status_d = ST_DROP_ZERO;
					end else if (q_empty) begin
						status_d = ST_QUEUED;
						wr_en    = 1'b1;
						wr_data  = arrival;
						front_d  = arrival;
						count_d  = CW'(1);
					end else if (cmp_lower) begin
						// Overwrite the running job in place
						status_d    = ST_QUEUED;
						preempted_d = 1'b1;
						wr_en       = 1'b1;
						wr_data     = arrival;
						front_d     = arrival;
					end else begin
						// Walk from the tail; the front always stops the walk
						status_d = ST_QUEUED;
						rd_addr  = last_idx;
						idx_d    = last_idx;
						state_d  = S_INS;
					end
				end
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = AW'(idx_q + 1'b1);
				if (cmp_lower) begin
					// Advance: move this entry up one place and read the next lower
					wr_data = rd_q;
					rd_addr = AW'(idx_q - 1'b1);
					idx_d   = AW'(idx_q - 1'b1);
				end else begin
					wr_data = new_q;
					count_d = CW'(count_q + 1'b1);
					state_d = S_OUT;
				end
			end
			S_FIN: begin
				wr_en   = 1'b1;
				wr_addr = AW'(idx_q - 1'b1);
				wr_data = rd_q;
				if (idx_q == AW'(1)) begin
					front_d = rd_q;
				end
				if (idx_q == last_idx) begin
					count_d = CW'(count_q - 1'b1);
					state_d = S_OUT;
				end else begin
					rd_addr = AW'(idx_q + 1'b1);
					idx_d   = AW'(idx_q + 1'b1);
				end
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		front_q     <= front_d;
		new_q       <= new_d;
		status_q    <= status_d;
		preempted_q <= preempted_d;
	end

	logic [CW+3:0] count_wide;
	assign count_wide = {4'b0, count_q};

	assign out_valid          = (state_q == S_OUT);
	assign status             = status_q;
	assign preempted          = preempted_q;
	assign running_valid      = !q_empty;
	assign running_tag        = q_empty ? 8'd0 : front_q.tag;
	assign running_precedence = q_empty ? 8'd0 : front_q.prec;
	assign queue_count        = count_wide[3:0];

endmodule

// ===== tb/preemptive_priority_run_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_run_queue_unit_tb: self-checking bench for the run queue
// Drives arrival and finish transactions through the valid/ready input,
// predicts each result with a local sorted job list and compares every
// result transaction field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module preemptive_priority_run_queue_unit_tb
	import pprq_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	// Let the block settle after the last result before closing the run.
	localparam int unsigned SettleCycles = 24;

	// Everything one result transaction carries.
	typedef struct {
		status_t    status;
		logic       preempted;
		logic       running_valid;
		logic [7:0] running_tag;
		logic [7:0] running_precedence;
		logic [3:0] queue_count;
	} dispatch_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       kind;
	logic [7:0] job_tag;
	logic [7:0] job_precedence;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] status;
	logic       preempted;
	logic       running_valid;
	logic [7:0] running_tag;
	logic [7:0] running_precedence;
	logic [3:0] queue_count;

	// Predicted contents of the run queue, front entry is the running job.
	entry_t           job_list[$];
	// Results owed by the block, oldest first.
	dispatch_result_t expected_results[$];
	int unsigned      mismatch_count = 0;
	// Random gaps on both channels when set; cleared for back-to-back stretches.
	bit               idling_on = 1'b0;
	// Long receiver hold-off, counted down by the receiver process.
	int unsigned      rx_hold_cycles = 0;

	preemptive_priority_run_queue_unit DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.kind               (kind),
		.job_tag            (job_tag),
		.job_precedence     (job_precedence),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.preempted          (preempted),
		.running_valid      (running_valid),
		.running_tag        (running_tag),
		.running_precedence (running_precedence),
		.queue_count        (queue_count)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Apply one accepted transaction to the local job list and return the
	// result the block owes for it.
	function automatic dispatch_result_t apply_job_event(input kind_t ev_kind,
			input logic [7:0] tag, input logic [7:0] prec);
		dispatch_result_t res;
		entry_t           fresh;
		int unsigned      pos;
		res.preempted = 1'b0;
		if (ev_kind == KIND_FINISH) begin
			if (job_list.size() == 0) begin
				res.status = ST_FINISH_EMPTY;
			end else begin
				job_list.delete(0);
				res.status = ST_FINISHED;
			end
		end else if (job_list.size() >= QueueDepthDefault) begin
			// a full queue wins over the zero precedence rule
			res.status = ST_DROP_FULL;
		end else if (prec == 8'd0 && job_list.size() != 0) begin
			res.status = ST_DROP_ZERO;
		end else begin
			res.status = ST_QUEUED;
			fresh.tag  = tag;
			fresh.prec = prec;
			// land behind every job of equal or higher precedence
			pos = job_list.size();
			for (int i = 0; i < job_list.size(); i++) begin
				if (job_list[i].prec < prec) begin
					pos = i;
					break;
				end
			end
			if (pos == 0 && job_list.size() != 0) begin
				// discard the running job; the count stays put
				job_list[0]   = fresh;
				res.preempted = 1'b1;
			end else begin
				job_list.insert(pos, fresh);
			end
		end
		res.running_valid      = (job_list.size() != 0);
		res.running_tag        = res.running_valid ? job_list[0].tag  : 8'd0;
		res.running_precedence = res.running_valid ? job_list[0].prec : 8'd0;
		res.queue_count        = 4'(job_list.size());
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------------

	// Idle length in cycles: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (!idling_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Bias towards zero and a handful of small values so that ties are common.
	function automatic logic [7:0] pick_precedence();
		int unsigned roll;
		roll = $urandom_range(0, 7);
		if (roll == 0)
			return 8'd0;
		if (roll < 4)
			return 8'($urandom_range(1, 4));
		return 8'($urandom_range(0, 255));
	endfunction

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// Offer one transaction after a random gap and hold it until taken.
	// Valid stays high on return: the next send either replaces the payload
	// at the coming falling edge or drops valid there.
	task automatic send_job_event(input kind_t ev_kind, input logic [7:0] tag,
			input logic [7:0] prec);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		kind           <= ev_kind;
		job_tag        <= tag;
		job_precedence <= prec;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		expected_results.push_back(apply_job_event(ev_kind, tag, prec));
	endtask

	// Drop valid and hold the sender until every owed result has come back.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------------

	// Drive out_ready: honour a requested hold-off first, otherwise stall at
	// random when idling is enabled.
	initial begin : result_receiver
		int unsigned stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				out_ready      <= 1'b0;
				rx_hold_cycles = rx_hold_cycles - 1;
			end else if (stall_left > 0) begin
				out_ready  <= 1'b0;
				stall_left = stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if (idling_on && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic compare_field(input string field_name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field_name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin : result_check
		dispatch_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: status %0d, tag %0d",
					status, running_tag);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("status", want.status, status);
				compare_field("preempted", want.preempted, preempted);
				compare_field("running_valid", want.running_valid, running_valid);
				compare_field("running_tag", want.running_tag, running_tag);
				compare_field("running_precedence", want.running_precedence,
					running_precedence);
				compare_field("queue_count", want.queue_count, queue_count);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Finish on an empty queue, background job on an empty queue, a second
	// background job dropped, then a precedence-one job displacing it.
	task automatic test_empty_queue();
		send_job_event(KIND_FINISH, 8'h5A, 8'hA5);
		send_job_event(KIND_ARRIVAL, 8'h00, 8'd0);
		send_job_event(KIND_ARRIVAL, 8'h11, 8'd0);
		send_job_event(KIND_ARRIVAL, 8'h22, 8'd1);
		wait_for_drain();
	endtask

	// Equal precedence queues behind, higher precedence preempts, and a
	// middle precedence sorts into place.
	task automatic test_preemption_and_ties();
		send_job_event(KIND_ARRIVAL, 8'h30, 8'd1);
		send_job_event(KIND_ARRIVAL, 8'h31, 8'd200);
		send_job_event(KIND_ARRIVAL, 8'hFF, 8'd255);
		send_job_event(KIND_ARRIVAL, 8'h32, 8'd255);
		send_job_event(KIND_ARRIVAL, 8'h33, 8'd128);
		wait_for_drain();
	endtask

	// Fill to the depth, then offer a top-precedence and a background job:
	// both are dropped for a full queue. Retire two jobs afterwards.
	task automatic test_full_queue();
		logic [7:0] fill_prec[6] = '{8'd100, 8'd50, 8'd7, 8'd128, 8'd1, 8'd200};
		foreach (fill_prec[i])
			send_job_event(KIND_ARRIVAL, 8'(8'h40 + i), fill_prec[i]);
		send_job_event(KIND_ARRIVAL, 8'hAA, 8'd255);
		send_job_event(KIND_ARRIVAL, 8'h55, 8'd0);
		send_job_event(KIND_FINISH, 8'h00, 8'h00);
		send_job_event(KIND_FINISH, 8'hFF, 8'hFF);
		wait_for_drain();
	endtask

	// Pick fill-biased or drain-biased stretches at random so the queue swings
	// between empty and full.
	task automatic test_random_traffic(input int unsigned item_total);
		bit filling;
		filling = 1'b1;
		for (int n = 0; n < item_total; n++) begin
			if (n % 40 == 0)
				filling = $urandom_range(0, 1);
			if ($urandom_range(0, 99) < (filling ? 80 : 30))
				send_job_event(KIND_ARRIVAL, 8'($urandom_range(0, 255)),
					pick_precedence());
			else
				send_job_event(KIND_FINISH, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
		end
		wait_for_drain();
	endtask

	// Hold the receiver off for a long stretch while the sender keeps
	// offering back-to-back transactions, so the block stalls its input.
	task automatic test_back_pressure();
		bit saved_idling;
		saved_idling   = idling_on;
		idling_on      = 1'b0;
		rx_hold_cycles = 200;
		for (int n = 0; n < 30; n++)
			send_job_event(($urandom_range(0, 2) == 0) ? KIND_FINISH : KIND_ARRIVAL,
				8'($urandom_range(0, 255)), pick_precedence());
		wait_for_drain();
		idling_on = saved_idling;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		kind           = KIND_ARRIVAL;
		job_tag        = 8'd0;
		job_precedence = 8'd0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed cases back to back, then with idling
		test_empty_queue();
		test_preemption_and_ties();
		idling_on = 1'b1;
		test_full_queue();
		test_random_traffic(300);
		test_back_pressure();
		// back-to-back stretch with no idling on either side
		idling_on = 1'b0;
		test_random_traffic(300);

		wait_for_drain();
		repeat (SettleCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
